/* rtl/apgf_pkg.sv */
`default_nettype none
package apgf_pkg;

   // item command codes
   typedef enum logic [2:0] {
      CMD_START  = 3'd0,
      CMD_STOP   = 3'd1,
      CMD_HEADER = 3'd2,
      CMD_SAMPLE = 3'd3,
      CMD_READ   = 3'd4
   } cmd_type;

   // register index, taken from the word address
   typedef enum logic [0:0] {
      REG_MAX_GAP    = 1'b0,
      REG_FILL_VALUE = 1'b1
   } reg_idx_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_CALC,
      ST_FILL
   } state_type;

   typedef struct packed {
      logic [15:0] max_gap;
      logic [7:0]  fill_value;
   } cfg_type;

   localparam int          SEQ_W            = 16;
   localparam int          CSR_ADDR_W       = 3;
   localparam logic [15:0] MAX_GAP_RESET    = 16'd50;
   localparam logic [7:0]  FILL_VALUE_RESET = 8'h80;

endpackage
`default_nettype wire

/* rtl/apgf_ring_mem.sv */
`default_nettype none
module apgf_ring_mem #(
   parameter int RING_DEPTH = 16384
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [$clog2(RING_DEPTH)-1:0] wr_addr,
   input  wire logic [7:0]                    wr_data,
   input  wire logic                          rd_en,
   input  wire logic [$clog2(RING_DEPTH)-1:0] rd_addr,
   output logic      [7:0]                    rd_data
);

   logic [7:0] mem [RING_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/apgf_csr.sv */
`default_nettype none
module apgf_csr
   import apgf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic      [31:0]           prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   logic [15:0] max_gap_ff, max_gap_in;
   logic [7:0]  fill_value_ff, fill_value_in;
   logic        wr_hit;
   reg_idx_type reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = reg_idx_type'(paddr[CSR_ADDR_W-1]);
   assign wr_hit  = psel && penable && pwrite && pready;

   always_comb begin
      max_gap_in    = max_gap_ff;
      fill_value_in = fill_value_ff;
      if (wr_hit) begin
         unique case (reg_idx)
            REG_MAX_GAP:    max_gap_in    = pwdata[15:0];
            REG_FILL_VALUE: fill_value_in = pwdata[7:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_MAX_GAP:    prdata = {16'd0, max_gap_ff};
         REG_FILL_VALUE: prdata = {24'd0, fill_value_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_gap_ff    <= MAX_GAP_RESET;
         fill_value_ff <= FILL_VALUE_RESET;
      end else begin
         max_gap_ff    <= max_gap_in;
         fill_value_ff <= fill_value_in;
      end
   end

   assign cfg.max_gap    = max_gap_ff;
   assign cfg.fill_value = fill_value_ff;

endmodule
`default_nettype wire

/* rtl/apgf_ctrl.sv */
`default_nettype none
module apgf_ctrl
   import apgf_pkg::*;
#(
   parameter int RING_DEPTH     = 16384,
   parameter int PACKET_SAMPLES = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [2:0]                    req_command,
   input  wire logic [SEQ_W-1:0]              req_seq,
   input  wire logic [7:0]                    req_sample_count,
   input  wire logic [7:0]                    req_sample,
   input  wire cfg_type                       cfg,
   output logic                               mem_wr_en,
   output logic      [$clog2(RING_DEPTH)-1:0] mem_wr_addr,
   output logic      [7:0]                    mem_wr_data,
   output logic                               mem_rd_en,
   output logic      [$clog2(RING_DEPTH)-1:0] mem_rd_addr,
   input  wire logic [7:0]                    mem_rd_data,
   output logic                               rsp_strobe,
   output logic      [7:0]                    rsp_read_data,
   output logic                               rsp_read_valid,
   output logic                               rsp_is_recording,
   output logic      [14:0]                   rsp_fill_level,
   output logic      [31:0]                   rsp_packet_count,
   output logic      [31:0]                   rsp_drop_count,
   output logic      [31:0]                   rsp_overflow_count
);

   localparam int IDX_W = $clog2(RING_DEPTH);
   localparam int LVL_W = $clog2(RING_DEPTH + 1);
   localparam int PS_W  = $clog2(PACKET_SAMPLES + 1);
   localparam int TOT_W = SEQ_W + PS_W;
   localparam int CMP_W = (TOT_W > LVL_W) ? TOT_W : LVL_W;
   localparam logic [7:0]       PKT_LIMIT = 8'(PACKET_SAMPLES);
   localparam logic [LVL_W-1:0] LVL_FULL  = LVL_W'(RING_DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(RING_DEPTH - 1);

   state_type state_ff, state_in;

   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic             rec_ff, rec_in;
   logic             have_seq_ff, have_seq_in;
   logic [SEQ_W-1:0] prev_seq_ff, prev_seq_in;
   logic [7:0]       remain_ff, remain_in;
   logic             aborted_ff, aborted_in;
   logic [31:0]      packets_ff, packets_in;
   logic [31:0]      drops_ff, drops_in;
   logic [31:0]      overflows_ff, overflows_in;
   logic             strobe_ff, strobe_in;
   logic             rd_hit_ff, rd_hit_in;

   // payload registers of the fill sequence
   logic [SEQ_W-1:0] gap_ff, gap_in;
   logic [TOT_W-1:0] total_ff, total_in;
   logic [LVL_W-1:0] fill_left_ff, fill_left_in;

   logic             accept;
   cmd_type          cmd;
   logic [SEQ_W-1:0] gap;
   logic             gap_hit;
   logic [7:0]       count_clamped;
   logic [LVL_W-1:0] room;
   logic             fill_over;

   function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] idx);
      idx_next = (idx == IDX_LAST) ? '0 : idx + 1'b1;
   endfunction

   assign busy          = (state_ff != ST_IDLE);
   assign accept        = start && !busy;
   assign cmd           = cmd_type'(req_command);
   assign gap           = req_seq - prev_seq_ff - 1'b1;
   assign gap_hit       = rec_ff && have_seq_ff && (gap != '0) && (gap <= cfg.max_gap);
   assign count_clamped = (req_sample_count > PKT_LIMIT) ? PKT_LIMIT : req_sample_count;
   assign room          = LVL_FULL - level_ff;
   assign fill_over     = CMP_W'(total_ff) > CMP_W'(room);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && cmd == CMD_HEADER && gap_hit) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: state_in = ST_CALC;
         ST_CALC: begin
            if (fill_over ? (room == '0) : (total_ff == '0)) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            if (fill_left_ff == LVL_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      wr_idx_in    = wr_idx_ff;
      rd_idx_in    = rd_idx_ff;
      level_in     = level_ff;
      rec_in       = rec_ff;
      have_seq_in  = have_seq_ff;
      prev_seq_in  = prev_seq_ff;
      remain_in    = remain_ff;
      aborted_in   = aborted_ff;
      packets_in   = packets_ff;
      drops_in     = drops_ff;
      overflows_in = overflows_ff;
      strobe_in    = 1'b0;
      rd_hit_in    = rd_hit_ff;
      gap_in       = gap_ff;
      total_in     = total_ff;
      fill_left_in = fill_left_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = wr_idx_ff;
      mem_wr_data  = req_sample;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = rd_idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rd_hit_in = 1'b0;
               strobe_in = 1'b1;
               unique case (cmd)
                  CMD_START: begin
                     if (!rec_ff) begin
                        wr_idx_in    = '0;
                        rd_idx_in    = '0;
                        level_in     = '0;
                        packets_in   = '0;
                        drops_in     = '0;
                        overflows_in = '0;
                        have_seq_in  = 1'b0;
                        remain_in    = '0;
                        aborted_in   = 1'b0;
                        rec_in       = 1'b1;
                     end
                  end
                  CMD_STOP: begin
                     if (rec_ff) begin
                        rec_in     = 1'b0;
                        remain_in  = '0;
                        aborted_in = 1'b0;
                     end
                  end
                  CMD_HEADER: begin
                     if (rec_ff) begin
                        if (gap_hit) begin
                           drops_in  = drops_ff + 32'(gap);
                           gap_in    = gap;
                           strobe_in = 1'b0;
                        end
                        prev_seq_in = req_seq;
                        have_seq_in = 1'b1;
                        remain_in   = count_clamped;
                        aborted_in  = 1'b0;
                        packets_in  = packets_ff + 32'd1;
                     end
                  end
                  CMD_SAMPLE: begin
                     if (rec_ff && remain_ff != '0) begin
                        remain_in = remain_ff - 1'b1;
                        if (!aborted_ff) begin
                           if (level_ff == LVL_FULL) begin
                              overflows_in = overflows_ff + 32'd1;
                              aborted_in   = 1'b1;
                           end else begin
                              mem_wr_en = 1'b1;
                              wr_idx_in = idx_next(wr_idx_ff);
                              level_in  = level_ff + 1'b1;
                           end
                        end
                     end
                  end
                  CMD_READ: begin
                     if (level_ff != '0) begin
                        mem_rd_en = 1'b1;
                        rd_idx_in = idx_next(rd_idx_ff);
                        level_in  = level_ff - 1'b1;
                        rd_hit_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_MUL: begin
            total_in = TOT_W'(gap_ff) * TOT_W'(PACKET_SAMPLES);
         end
         ST_CALC: begin
            if (fill_over) begin
               overflows_in = overflows_ff + 32'd1;
               fill_left_in = room;
            end else begin
               fill_left_in = LVL_W'(total_ff);
            end
            if (fill_over ? (room == '0) : (total_ff == '0)) begin
               strobe_in = 1'b1;
            end
         end
         ST_FILL: begin
            mem_wr_en    = 1'b1;
            mem_wr_data  = cfg.fill_value;
            wr_idx_in    = idx_next(wr_idx_ff);
            level_in     = level_ff + 1'b1;
            fill_left_in = fill_left_ff - 1'b1;
            if (fill_left_ff == LVL_W'(1)) begin
               strobe_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         level_ff     <= '0;
         rec_ff       <= 1'b0;
         have_seq_ff  <= 1'b0;
         prev_seq_ff  <= '0;
         remain_ff    <= '0;
         aborted_ff   <= 1'b0;
         packets_ff   <= '0;
         drops_ff     <= '0;
         overflows_ff <= '0;
         strobe_ff    <= 1'b0;
         rd_hit_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         level_ff     <= level_in;
         rec_ff       <= rec_in;
         have_seq_ff  <= have_seq_in;
         prev_seq_ff  <= prev_seq_in;
         remain_ff    <= remain_in;
         aborted_ff   <= aborted_in;
         packets_ff   <= packets_in;
         drops_ff     <= drops_in;
         overflows_ff <= overflows_in;
         strobe_ff    <= strobe_in;
         rd_hit_ff    <= rd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      gap_ff       <= gap_in;
      total_ff     <= total_in;
      fill_left_ff <= fill_left_in;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_read_valid     = rd_hit_ff;
   assign rsp_read_data      = rd_hit_ff ? mem_rd_data : 8'd0;
   assign rsp_is_recording   = rec_ff;
   assign rsp_fill_level     = 15'(level_ff);
   assign rsp_packet_count   = packets_ff;
   assign rsp_drop_count     = drops_ff;
   assign rsp_overflow_count = overflows_ff;

endmodule
`default_nettype wire

/* rtl/audio_packet_gap_fill_ring_core.sv */
// audio byte ring with silence fill for missing packets
//
// item channel: an item (command plus header/sample fields) is taken on a
//   rising edge with start high and busy low; commands are start, stop,
//   packet header, sample byte and read byte
// result channel: one result per item, shown for exactly one cycle with
//   rsp_strobe high; the receiver has no way to stall it
// register port: apb-style, max_gap at byte 0 and fill_value at byte 4,
//   pready tied high; write only while no item is in flight
// timing: start, stop, sample, read and headers without a gap take one
//   cycle, the result appears in the next cycle and busy stays low
// a header that opens a filled gap of n bytes keeps busy high for 2 + n
//   cycles (gap multiply, room check, then one fill byte per cycle through
//   the single ring write port); its result follows the last fill write
// reset: pointers, counters and flags clear, registers return to 50 and
//   0x80; ring contents are not cleared and are read only after written
`default_nettype none
module audio_packet_gap_fill_ring_core
   import apgf_pkg::*;
#(
   parameter int RING_DEPTH     = 16384,
   parameter int PACKET_SAMPLES = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // item channel
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [2:0]            req_command,
   input  wire logic [SEQ_W-1:0]      req_seq,
   input  wire logic [7:0]            req_sample_count,
   input  wire logic [7:0]            req_sample,
   // result channel
   output logic                       rsp_strobe,
   output logic      [7:0]            rsp_read_data,
   output logic                       rsp_read_valid,
   output logic                       rsp_is_recording,
   output logic      [14:0]           rsp_fill_level,
   output logic      [31:0]           rsp_packet_count,
   output logic      [31:0]           rsp_drop_count,
   output logic      [31:0]           rsp_overflow_count,
   // register port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic      [31:0]           prdata,
   output logic                       pready
);

   localparam int IDX_W = $clog2(RING_DEPTH);

   cfg_type          cfg;
   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   logic [7:0]       mem_wr_data;
   logic             mem_rd_en;
   logic [IDX_W-1:0] mem_rd_addr;
   logic [7:0]       mem_rd_data;

   // configuration registers
   apgf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // item sequencer: counters, pointers, gap fill walk
   apgf_ctrl #(
      .RING_DEPTH     (RING_DEPTH),
      .PACKET_SAMPLES (PACKET_SAMPLES)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_seq            (req_seq),
      .req_sample_count   (req_sample_count),
      .req_sample         (req_sample),
      .cfg                (cfg),
      .mem_wr_en          (mem_wr_en),
      .mem_wr_addr        (mem_wr_addr),
      .mem_wr_data        (mem_wr_data),
      .mem_rd_en          (mem_rd_en),
      .mem_rd_addr        (mem_rd_addr),
      .mem_rd_data        (mem_rd_data),
      .rsp_strobe         (rsp_strobe),
      .rsp_read_data      (rsp_read_data),
      .rsp_read_valid     (rsp_read_valid),
      .rsp_is_recording   (rsp_is_recording),
      .rsp_fill_level     (rsp_fill_level),
      .rsp_packet_count   (rsp_packet_count),
      .rsp_drop_count     (rsp_drop_count),
      .rsp_overflow_count (rsp_overflow_count)
   );

   // byte ring, one write and one registered read per cycle
   apgf_ring_mem #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule
`default_nettype wire
